/* rtl/core/sac_pkg.sv */
`timescale 1ns / 1ps
package sac_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_LAGS    = 16;
    localparam int SAMPLE_W    = 16;
    localparam int ADDR_W      = 10;
    localparam int CNT_W       = 11;
    localparam int SUM_W       = 27;
    localparam int MEAN_W      = 25;
    localparam int DEV_W       = 26;
    localparam int PROD_W      = 2 * DEV_W;
    localparam int ACC_W       = 62;
    localparam int VAL_W       = 48;
    localparam int LAG_W       = 5;
    localparam int DIVD_W      = 64;
    localparam int DIVS_W      = 48;

    localparam logic CFG_NUM_LAGS  = 1'b0;
    localparam logic CFG_CORR_MODE = 1'b1;

    typedef logic signed [DEV_W-1:0] t_dev;
    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic clear;
        logic step;
        logic shift;
    } t_cell_ctrl;

endpackage

/* rtl/core/sample_autocorrelation_core.sv */
`timescale 1ns / 1ps
// sample autocorrelation core
// input channel: i_in_valid / o_in_stall carry one signed sample and a last
// mark per request. samples are stored (up to 1024); extra ones are dropped
// and flag overflow. a last mark starts the run, during which o_in_stall is
// high until the final result is taken.
// run: mean by iterative division, then the samples stream once through a
// chain of 16 lag cells, one sample per cycle, each cell doing one
// multiply-accumulate per sample.
// output channel: o_out_valid / i_out_stall, one request per lag from 0 to
// num_lags-1, num_lags clamped to 1..16; each lag below the sample count
// takes one division (two in correlation mode unless lag 0 gave zero).
// a result waits in the output register while the receiver stalls.
// config: i_cfg_we writes i_cfg_data to the register at i_cfg_index; the user
// must write only while the core is idle, the core does not enforce it.
// reset (synchronous, active low) clears count, sum, flags and registers;
// the sample memory needs no clearing since only written entries are read.
module sample_autocorrelation_core
    import sac_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [4:0]                 i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [3:0]                 o_lag_index,
    output logic signed [VAL_W-1:0]    o_lag_value,
    output logic                       o_zero_divisor,
    output logic                       o_overflowed,
    output logic                       o_last_lag
);

    typedef enum logic [6:0] {
        S_LOAD   = 7'b0000001,
        S_MEAN   = 7'b0000010,
        S_STREAM = 7'b0000100,
        S_LAG    = 7'b0001000,
        S_CDIV   = 7'b0010000,
        S_RDIV   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    localparam logic [VAL_W-1:0] POS48 = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] NEG48 = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [DIVD_W-1:0] CORR_CAP = DIVD_W'(131072);

    t_state r_state;

    // config registers
    logic [4:0] r_num_lags;
    logic       r_corr;

    // sample memory
    logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_rd_v;
    logic [CNT_W-1:0]    r_rd_addr;
    logic                r_issue_done;
    logic [1:0]          r_drain;

    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [MEAN_W-1:0] r_mean;
    logic                     r_ovf;

    // per-lag work
    logic [LAG_W-1:0]        r_lag;
    logic                    r_neg;
    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] r_lz;

    // output register
    logic                    r_out_v;
    logic                    r_out_show;
    logic [3:0]              r_out_lag;
    logic signed [VAL_W-1:0] r_out_val;
    logic                    r_out_zdiv;
    logic                    r_out_ovf;
    logic                    r_out_last;

    // divider
    logic              r_div_start;
    logic [DIVD_W-1:0] r_div_dvd;
    logic [DIVS_W-1:0] r_div_dvs;
    logic              w_div_done;
    logic [DIVD_W-1:0] w_div_q;

    logic             w_in_acc;
    logic             w_full;
    logic [LAG_W-1:0] w_lags;
    t_dev             w_dev;
    t_cell_ctrl       w_ctrl;
    logic             r_shift;
    logic             r_clear;

    t_dev tap   [MAX_LAGS+1];
    logic tap_v [MAX_LAGS+1];
    t_acc acc   [MAX_LAGS+1];

    logic signed [VAL_W-1:0] w_sat;
    logic signed [VAL_W-1:0] w_lz_now;
    logic [VAL_W-1:0]        w_abs_val;
    logic [VAL_W-1:0]        w_abs_lz;
    logic [DIVD_W-1:0]       w_cq;
    t_acc                    w_acc0;
    logic signed [SUM_W-1:0] w_sum_next;
    logic [SUM_W-1:0]        w_sum_abs;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_full   = (r_count == CNT_W'(MAX_SAMPLES));
    assign w_acc0   = acc[0];

    // sum including the sample taken this cycle, for the mean division
    assign w_sum_next = w_full ? r_sum : r_sum + SUM_W'(i_sample);
    assign w_sum_abs  = w_sum_next[SUM_W-1] ? SUM_W'(-w_sum_next) : SUM_W'(w_sum_next);

    // clamp lag count to 1..MAX_LAGS
    always_comb begin
        if (r_num_lags == '0) begin
            w_lags = LAG_W'(1);
        end else if (r_num_lags > LAG_W'(MAX_LAGS)) begin
            w_lags = LAG_W'(MAX_LAGS);
        end else begin
            w_lags = r_num_lags;
        end
    end

    // deviation from the mean, 8 fraction bits
    assign w_dev = {{(DEV_W-SAMPLE_W-8){r_rd_data[SAMPLE_W-1]}}, r_rd_data, 8'b0}
                 - {{(DEV_W-MEAN_W){r_mean[MEAN_W-1]}}, r_mean};

    assign w_ctrl.clear = r_clear;
    assign w_ctrl.step  = r_rd_v;
    assign w_ctrl.shift = r_shift;

    // lag cell chain: cell k sees the deviation k samples back
    assign tap[0]        = w_dev;
    assign tap_v[0]      = 1'b1;
    assign acc[MAX_LAGS] = '0;

    for (genvar k = 0; k < MAX_LAGS; k++) begin : g_cell
        sac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_dev   (w_dev),
            .i_tap   (tap[k]),
            .i_tap_v (tap_v[k]),
            .i_acc   (acc[k+1]),
            .o_tap   (tap[k+1]),
            .o_tap_v (tap_v[k+1]),
            .o_acc   (acc[k])
        );
    end

    sac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // covariance saturation to 48 bits
    always_comb begin
        if (r_neg) begin
            if (w_div_q >= DIVD_W'(NEG48)) begin
                w_sat = NEG48;
            end else begin
                w_sat = -$signed(w_div_q[VAL_W-1:0]);
            end
        end else if (w_div_q > DIVD_W'(POS48)) begin
            w_sat = POS48;
        end else begin
            w_sat = w_div_q[VAL_W-1:0];
        end
    end

    assign w_lz_now  = (r_lag == '0) ? w_sat : r_lz;
    assign w_abs_val = w_sat[VAL_W-1] ? VAL_W'(-w_sat) : VAL_W'(w_sat);
    assign w_abs_lz  = w_lz_now[VAL_W-1] ? VAL_W'(-w_lz_now) : VAL_W'(w_lz_now);
    assign w_cq      = (w_div_q > CORR_CAP) ? CORR_CAP : w_div_q;

    // sample memory ports
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_full) begin
            mem[r_count[ADDR_W-1:0]] <= i_sample;
        end
        r_rd_data <= mem[r_rd_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_num_lags   <= 5'd15;
            r_corr       <= 1'b0;
            r_count      <= '0;
            r_sum        <= '0;
            r_mean       <= '0;
            r_ovf        <= 1'b0;
            r_lz         <= '0;
            r_rd_v       <= 1'b0;
            r_rd_addr    <= '0;
            r_issue_done <= 1'b0;
            r_drain      <= '0;
            r_lag        <= '0;
            r_out_v      <= 1'b0;
            r_div_start  <= 1'b0;
            r_shift      <= 1'b0;
            r_clear      <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_shift     <= 1'b0;
            r_clear     <= 1'b0;
            r_rd_v      <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_LAGS:  r_num_lags <= i_cfg_data;
                    CFG_CORR_MODE: r_corr     <= i_cfg_data[0];
                    default:       ;
                endcase
            end

            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                            r_sum   <= r_sum + SUM_W'(i_sample);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_sample) begin
                            // mean magnitude: |sum| * 256 / count
                            r_div_dvd   <= DIVD_W'({w_sum_abs, 8'b0});
                            r_div_dvs   <= DIVS_W'(w_full ? r_count : r_count + 1'b1);
                            r_state     <= S_MEAN;
                            r_div_start <= 1'b1;
                            r_clear     <= 1'b1;
                        end
                    end
                end
                S_MEAN: begin
                    if (w_div_done) begin
                        r_mean       <= r_sum[SUM_W-1] ? -$signed(w_div_q[MEAN_W-1:0])
                                                       : $signed(w_div_q[MEAN_W-1:0]);
                        r_rd_addr    <= '0;
                        r_issue_done <= 1'b0;
                        r_drain      <= '0;
                        r_state      <= S_STREAM;
                    end
                end
                S_STREAM: begin
                    if (!r_issue_done) begin
                        r_rd_v    <= 1'b1;
                        r_rd_addr <= r_rd_addr + 1'b1;
                        if (r_rd_addr + 1'b1 == r_count) begin
                            r_issue_done <= 1'b1;
                        end
                    end else if (!r_rd_v) begin
                        // product and accumulate stages drain
                        r_drain <= r_drain + 1'b1;
                        if (r_drain == 2'd2) begin
                            r_lag   <= '0;
                            r_state <= S_LAG;
                        end
                    end
                end
                S_LAG: begin
                    if (CNT_W'(r_lag) >= r_count) begin
                        r_val      <= '0;
                        r_out_zdiv <= 1'b1;
                        r_state    <= S_OUT;
                        r_out_v    <= 1'b1;
                        r_shift    <= 1'b1;
                    end else begin
                        r_neg       <= w_acc0[ACC_W-1];
                        r_div_dvd   <= DIVD_W'(w_acc0[ACC_W-1] ? -w_acc0 : w_acc0);
                        r_div_dvs   <= DIVS_W'(r_count - CNT_W'(r_lag));
                        r_div_start <= 1'b1;
                        r_state     <= S_CDIV;
                    end
                end
                S_CDIV: begin
                    if (w_div_done) begin
                        if (r_lag == '0) begin
                            r_lz <= w_sat;
                        end
                        if (r_corr && w_lz_now == '0) begin
                            r_val      <= '0;
                            r_out_zdiv <= 1'b1;
                            r_out_v    <= 1'b1;
                            r_shift    <= 1'b1;
                            r_state    <= S_OUT;
                        end else if (r_corr) begin
                            r_neg       <= w_sat[VAL_W-1] ^ w_lz_now[VAL_W-1];
                            r_div_dvd   <= {w_abs_val, 16'b0};
                            r_div_dvs   <= w_abs_lz;
                            r_div_start <= 1'b1;
                            r_state     <= S_RDIV;
                        end else begin
                            r_val      <= w_sat;
                            r_out_zdiv <= 1'b0;
                            r_out_v    <= 1'b1;
                            r_shift    <= 1'b1;
                            r_state    <= S_OUT;
                        end
                    end
                end
                S_RDIV: begin
                    if (w_div_done) begin
                        r_val      <= r_neg ? -$signed(w_cq[VAL_W-1:0])
                                            : $signed(w_cq[VAL_W-1:0]);
                        r_out_zdiv <= 1'b0;
                        r_out_v    <= 1'b1;
                        r_shift    <= 1'b1;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_out_show && !i_out_stall) begin
                        r_out_v <= 1'b0;
                        if (r_out_last) begin
                            r_count <= '0;
                            r_sum   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_lag   <= r_lag + 1'b1;
                            r_state <= S_LAG;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // result fields, captured as the request is raised
    always_ff @(posedge i_clk) begin
        if (r_shift) begin
            r_out_val  <= r_val;
            r_out_lag  <= r_lag[3:0];
            r_out_ovf  <= r_ovf;
            r_out_last <= (r_lag + 1'b1 == w_lags);
        end
    end

    // r_out_v is raised together with r_shift; the fields land in the following
    // cycle, so the visible request (r_out_show) waits for them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_show <= 1'b0;
        end else begin
            r_out_show <= r_out_v && !(r_out_show && !i_out_stall);
        end
    end

    assign o_in_stall     = (r_state != S_LOAD);
    assign o_out_valid    = r_out_show;
    assign o_lag_index    = r_out_lag;
    assign o_lag_value    = r_out_val;
    assign o_zero_divisor = r_out_zdiv;
    assign o_overflowed   = r_out_ovf;
    assign o_last_lag     = r_out_last;

endmodule

/* rtl/core/sac_div.sv */
`timescale 1ns / 1ps
module sac_div
    import sac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(DIVD_W + 1);

    logic [DIVS_W:0]     r_rem, n_rem;
    logic [DIVD_W-1:0]   r_quo, n_quo;
    logic [DIVS_W-1:0]   r_div;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy, r_done;
    logic [DIVS_W:0]     w_shift, w_trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_shift = {r_rem[DIVS_W-1:0], r_quo[DIVD_W-1]};
        w_trial = w_shift - {1'b0, r_div};
        if (!w_trial[DIVS_W]) begin
            n_rem = w_trial;
            n_quo = {r_quo[DIVD_W-2:0], 1'b1};
        end else begin
            n_rem = w_shift;
            n_quo = {r_quo[DIVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/sac_cell.sv */
`timescale 1ns / 1ps
module sac_cell
    import sac_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_dev       i_dev,
    input  t_dev       i_tap,
    input  logic       i_tap_v,
    input  t_acc       i_acc,
    output t_dev       o_tap,
    output logic       o_tap_v,
    output t_acc       o_acc
);

    t_dev                     r_tap;
    logic                     r_tap_v;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    t_acc                     r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_tap_v <= 1'b0;
            r_pv    <= 1'b0;
            r_acc   <= '0;
        end else begin
            if (i_ctrl.step) begin
                r_tap_v <= i_tap_v;
            end
            r_pv <= i_ctrl.step & i_tap_v;
            if (i_ctrl.shift) begin
                r_acc <= i_acc;
            end else if (r_pv) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_tap <= i_tap;
        end
        r_prod <= i_dev * i_tap;
    end

    assign o_tap   = r_tap;
    assign o_tap_v = r_tap_v;
    assign o_acc   = r_acc;

endmodule

/* dv/sac_lag_checker.sv */
`timescale 1ns / 1ps
module sac_lag_checker
    import sac_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [4:0]                 i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [3:0]                 i_lag_index,
    input  logic signed [VAL_W-1:0]    i_lag_value,
    input  logic                       i_zero_divisor,
    input  logic                       i_overflowed,
    input  logic                       i_last_lag,
    output int                         o_errors,
    output int                         o_pending
);

    typedef struct {
        logic [3:0]        lag;
        logic [VAL_W-1:0]  value;
        logic              zdiv;
        logic              ovf;
        logic              last;
    } t_lag_result;

    localparam longint unsigned POS48 = (64'd1 << 47) - 1;
    localparam longint unsigned NEG48 = 64'd1 << 47;
    localparam longint unsigned CORR_CAP = 64'd131072;

    t_lag_result lag_results_q[$];

    logic signed [SAMPLE_W-1:0] series_mem [MAX_SAMPLES];
    int          series_len;
    longint      series_sum;
    longint      mean_fx;
    longint      lag0_fx;
    logic        ovf_seen;
    logic [4:0]  lags_reg;
    logic        corr_reg;

    // predicts all lag results of one finished series
    task automatic predict_lags();
        int          lags;
        longint      dev_a, dev_b, val;
        longint unsigned acc, mag, quo;
        logic        neg, zd;
        t_lag_result r;
        mean_fx = (series_sum * 256) / longint'(series_len);
        lags = (lags_reg < 1) ? 1 : ((lags_reg > MAX_LAGS) ? MAX_LAGS : int'(lags_reg));
        for (int lag = 0; lag < lags; lag++) begin
            val = 0;
            zd = 1'b0;
            if (lag >= series_len) begin
                zd = 1'b1;
            end else begin
                acc = 0;
                for (int j = 0; j + lag < series_len; j++) begin
                    dev_a = longint'(series_mem[j]) * 256 - mean_fx;
                    dev_b = longint'(series_mem[j+lag]) * 256 - mean_fx;
                    acc += longint'(dev_a * dev_b);
                end
                neg = acc[63];
                mag = neg ? (64'd0 - acc) : acc;
                quo = mag / longint'(series_len - lag);
                if (neg)
                    val = (quo >= NEG48) ? -longint'(NEG48) : -longint'(quo);
                else
                    val = (quo > POS48) ? longint'(POS48) : longint'(quo);
            end
            if (lag == 0)
                lag0_fx = zd ? 0 : val;
            if (corr_reg && !zd) begin
                if (lag0_fx == 0) begin
                    zd = 1'b1;
                    val = 0;
                end else begin
                    mag = longint'(val < 0 ? -val : val);
                    quo = (mag << 16) / longint'(lag0_fx < 0 ? -lag0_fx : lag0_fx);
                    if (quo > CORR_CAP)
                        quo = CORR_CAP;
                    val = ((val < 0) != (lag0_fx < 0)) ? -longint'(quo) : longint'(quo);
                end
            end
            r.lag   = lag[3:0];
            r.value = val[VAL_W-1:0];
            r.zdiv  = zd;
            r.ovf   = ovf_seen;
            r.last  = (lag + 1 == lags);
            lag_results_q.push_back(r);
        end
        series_len = 0;
        series_sum = 0;
        ovf_seen = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_lag_result exp_r;
        if (!i_rst_n) begin
            lag_results_q.delete();
            series_len = 0;
            series_sum = 0;
            mean_fx    = 0;
            lag0_fx    = 0;
            ovf_seen   = 1'b0;
            lags_reg   = 5'd15;
            corr_reg   = 1'b0;
            o_errors   = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_NUM_LAGS)
                    lags_reg = i_cfg_data;
                else if (i_cfg_index == CFG_CORR_MODE)
                    corr_reg = i_cfg_data[0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (lag_results_q.size() == 0) begin
                    $display("%0t: unexpected result lag %0d value %0d", $time,
                             i_lag_index, i_lag_value);
                    o_errors++;
                end else begin
                    exp_r = lag_results_q.pop_front();
                    if (i_lag_index !== exp_r.lag || i_lag_value !== exp_r.value
                        || i_zero_divisor !== exp_r.zdiv || i_overflowed !== exp_r.ovf
                        || i_last_lag !== exp_r.last) begin
                        $display("%0t: mismatch expected lag %0d val %0d zd %b ov %b last %b",
                                 $time, exp_r.lag, $signed(exp_r.value), exp_r.zdiv,
                                 exp_r.ovf, exp_r.last);
                        $display("%0t:          actual   lag %0d val %0d zd %b ov %b last %b",
                                 $time, i_lag_index, i_lag_value, i_zero_divisor,
                                 i_overflowed, i_last_lag);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (series_len < MAX_SAMPLES) begin
                    series_mem[series_len] = i_sample;
                    series_len++;
                    series_sum += longint'(i_sample);
                end else begin
                    ovf_seen = 1'b1;
                end
                if (i_last_sample)
                    predict_lags();
            end
        end
        o_pending = lag_results_q.size();
    end

endmodule

/* dv/tb_sample_autocorrelation_core.sv */
`timescale 1ns / 1ps
module tb_sample_autocorrelation_core;
    import sac_pkg::*;

    localparam int IDLE_LIMIT = 40000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic                       i_cfg_index;
    logic [4:0]                 i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_last_sample;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [3:0]                 o_lag_index;
    logic signed [VAL_W-1:0]    o_lag_value;
    logic                       o_zero_divisor;
    logic                       o_overflowed;
    logic                       o_last_lag;

    int error_count;
    int pending_count;
    int idle_pct;
    int stall_pct;
    int sample_total;
    int quiet_cycles;

    sample_autocorrelation_core uut (.*);

    sac_lag_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_sample, .i_last_sample,
        .i_out_valid(o_out_valid), .i_out_stall, .i_lag_index(o_lag_index),
        .i_lag_value(o_lag_value), .i_zero_divisor(o_zero_divisor),
        .i_overflowed(o_overflowed), .i_last_lag(o_last_lag),
        .o_errors(error_count), .o_pending(pending_count)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver side: random stall decided at every falling edge
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog on cycles with no accepted request on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("sample_autocorrelation_core verification failed");
            $finish;
        end
    end

    // one register write, only while the core is idle
    task automatic write_reg(input logic idx, input logic [4:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // wait until every lag result of the last series has been taken
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // one sample request, holding valid until accepted
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_sample      = s;
        i_last_sample = last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        sample_total++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1:       return $signed(16'($urandom_range(0, 64))) - 16'sd32;
            2:       return 16'sd1000 + $signed(16'($urandom_range(0, 50)));
            default: return 16'($urandom);
        endcase
    endfunction

    // a whole series of random samples ending in a last mark
    task automatic send_series(input int len);
        for (int k = 0; k < len; k++)
            send_sample(rand_sample(), k == len - 1);
    endtask

    // per-series traffic profile: none, sender gaps, receiver stalls, both
    task automatic pick_phase(input int ph);
        case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 60; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 60; end
            default: begin idle_pct = 24; stall_pct = 24; end
        endcase
    endtask

    initial begin
        int series_idx;
        int len;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_NUM_LAGS;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_sample      = '0;
        i_last_sample = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        sample_total  = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset settings, alternating full-scale extremes
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b1);
        wait_drained();

        // all lags, single sample: every lag past the first has no divisor
        write_reg(CFG_NUM_LAGS, 5'd16);
        send_sample(16'sh8000, 1'b1);
        wait_drained();

        // constant series in correlation mode: zero variance
        write_reg(CFG_CORR_MODE, 1'b1);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b1);
        wait_drained();

        // zero lags treated as one
        write_reg(CFG_NUM_LAGS, 5'd0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd3, 1'b1);
        wait_drained();

        // oversize lag count, positive mean, correlation
        write_reg(CFG_NUM_LAGS, 5'd31);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd1, 1'b1);
        wait_drained();

        // store overflow: dropped samples, last mark on a dropped one
        write_reg(CFG_CORR_MODE, 1'b0);
        write_reg(CFG_NUM_LAGS, 5'd4);
        send_series(MAX_SAMPLES + 6);
        wait_drained();

        // random series with random settings
        sample_total = 0;
        series_idx = 0;
        while (sample_total < 170) begin
            pick_phase(series_idx);
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_NUM_LAGS, 5'd1);
                1:       write_reg(CFG_NUM_LAGS, 5'd16);
                default: write_reg(CFG_NUM_LAGS, 5'($urandom_range(0, 31)));
            endcase
            write_reg(CFG_CORR_MODE, 1'($urandom_range(0, 1)));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                              : $urandom_range(1, 18);
            send_series(len);
            i_in_valid = 1'b0;
            wait_drained();
            series_idx++;
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (200) @(negedge i_clk);
        if (error_count == 0 && pending_count == 0)
            $display("sample_autocorrelation_core verification clean");
        else
            $display("sample_autocorrelation_core verification failed");
        $finish;
    end

endmodule
